>>> rtl/stxrx_pkg.sv
// Shared types, constants and the CRC-16 byte update for the framed packet receiver.
package stxrx_pkg;

	// Default payload limit handed to the top level parameter.
	localparam int unsigned MaxPayloadDef = 1024;

	// Register reset values.
	localparam logic [7:0] StartByteRst = 8'h02;
	localparam logic [7:0] EndByteRst   = 8'h03;
	localparam logic [7:0] CmdTypeRst   = 8'h00;

	// Configuration register indexes.
	localparam logic [1:0] RegStartByte   = 2'd0;
	localparam logic [1:0] RegEndByte     = 2'd1;
	localparam logic [1:0] RegCommandType = 2'd2;

	// CRC-16/MODBUS: reflected polynomial, all-ones start value, no final xor.
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_TOO_LONG     = 3'd1,
		ST_END_MISSING  = 3'd2,
		ST_CRC_MISMATCH = 3'd3,
		ST_BAD_TYPE     = 3'd4,
		ST_EMPTY        = 3'd5
	} status_t;

	// One result item as it travels through the output buffer.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [9:0]  data_index;
		logic [7:0]  frame_type;
		logic [15:0] frame_length;
		status_t     status;
	} result_t;

	// Folds one byte into the running CRC, one polynomial step per bit.
	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] v;
		v = {8'h00, crc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
		end
		return {8'h00, crc[15:8]} ^ v;
	endfunction

endpackage

>>> rtl/stxrx_out_buf.sv
// Two-entry output buffer (output register plus skid entry) for result items.
module stxrx_out_buf
	import stxrx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    out_fire;

	assign out_fire  = out_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Valid flags: the skid entry only fills when the output register is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload moves with the flags above and needs no reset.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (!out_valid_q || out_fire) begin
				out_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

endmodule

>>> rtl/stx_etx_frame_receiver_crc16_unit.sv
// Top level of the framed packet receiver with CRC-16/MODBUS check.
// The receiver takes one byte per clock cycle. While hunting it drops bytes
// until the start byte arrives, then reads a type byte, a little-endian 16-bit
// length, the payload, a little-endian CRC and a final byte. Each payload byte
// with index below MAX_PAYLOAD is delivered as a data result with its index;
// the final byte yields one status result. The framing state and the CRC are
// updated in the same cycle as the byte transfer, and the result lands in a
// two-entry output buffer, so the input stalls only when both entries are full.
// Register writes are taken at any time (cfg_ready is always high) and are
// meant to happen while no frame is in progress.
module stx_etx_frame_receiver_crc16_unit
	import stxrx_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MaxPayloadDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  data_byte,
	output logic [9:0]  data_index,
	output logic [7:0]  frame_type,
	output logic [15:0] frame_length,
	output logic [2:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam logic [16:0] MaxPayload = 17'(MAX_PAYLOAD);

	logic [7:0]  start_byte_q;
	logic [7:0]  end_byte_q;
	logic [7:0]  cmd_type_q;

	logic        in_frame_q;
	logic [16:0] pos_q;
	logic [7:0]  type_q;
	logic [15:0] len_q;
	logic [15:0] crc_q;
	logic [15:0] rx_crc_q;

	logic        in_frame_d;
	logic [16:0] pos_d;
	logic [7:0]  type_d;
	logic [15:0] len_d;
	logic [15:0] crc_d;
	logic [15:0] rx_crc_d;

	logic        in_fire;
	logic        res_valid;
	result_t     res;
	result_t     out_data;
	logic        buf_space;

	logic [16:0] len_plus4;
	logic [16:0] len_plus5;
	logic [16:0] idx;
	logic [16:0] pos_inc;

	assign cfg_ready = 1'b1;
	assign in_ready  = buf_space;
	assign in_fire   = in_valid && in_ready;

	// Configuration registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= StartByteRst;
			end_byte_q   <= EndByteRst;
			cmd_type_q   <= CmdTypeRst;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == RegStartByte) begin
				start_byte_q <= cfg_data;
			end else if (cfg_index == RegEndByte) begin
				end_byte_q <= cfg_data;
			end else if (cfg_index == RegCommandType) begin
				cmd_type_q <= cfg_data;
			end
		end
	end

	assign len_plus4 = {1'b0, len_q} + 17'd4;
	assign len_plus5 = {1'b0, len_q} + 17'd5;
	assign idx       = pos_q - 17'd4;
	assign pos_inc   = pos_q + 17'd1;

	// Frame parser: next state and the result caused by the current byte.
	always_comb begin
		in_frame_d = in_frame_q;
		pos_d      = pos_q;
		type_d     = type_q;
		len_d      = len_q;
		crc_d      = crc_q;
		rx_crc_d   = rx_crc_q;
		res_valid  = 1'b0;
		res        = '0;
		res.kind   = KIND_DATA;
		res.status = ST_OK;

		if (!in_frame_q) begin
			if (rx_byte == start_byte_q) begin
				in_frame_d = 1'b1;
				pos_d      = 17'd1;
				crc_d      = CrcInit;
			end
		end else if (pos_q == 17'd1) begin
			type_d = rx_byte;
			pos_d  = pos_inc;
		end else if (pos_q == 17'd2) begin
			len_d = {8'h00, rx_byte};
			pos_d = pos_inc;
		end else if (pos_q == 17'd3) begin
			len_d = {rx_byte, len_q[7:0]};
			pos_d = pos_inc;
		end else if (pos_q < len_plus4) begin
			// Payload byte: always folded, delivered only inside the limit.
			crc_d = crc16_fold(crc_q, rx_byte);
			pos_d = pos_inc;
			if (idx < MaxPayload) begin
				res_valid      = 1'b1;
				res.data_byte  = rx_byte;
				res.data_index = idx[9:0];
			end
		end else if (pos_q == len_plus4) begin
			rx_crc_d = {8'h00, rx_byte};
			pos_d    = pos_inc;
		end else if (pos_q == len_plus5) begin
			rx_crc_d = {rx_byte, rx_crc_q[7:0]};
			pos_d    = pos_inc;
		end else begin
			// Final byte: first failing check sets the status.
			res_valid        = 1'b1;
			res.kind         = KIND_DONE;
			res.frame_type   = type_q;
			res.frame_length = len_q;
			if ({1'b0, len_q} > MaxPayload) begin
				res.status = ST_TOO_LONG;
			end else if (rx_byte != end_byte_q) begin
				res.status = ST_END_MISSING;
			end else if (crc_q != rx_crc_q) begin
				res.status = ST_CRC_MISMATCH;
			end else if (type_q != cmd_type_q) begin
				res.status = ST_BAD_TYPE;
			end else if (len_q == 16'h0000) begin
				res.status = ST_EMPTY;
			end else begin
				res.status = ST_OK;
			end
			in_frame_d = 1'b0;
			pos_d      = '0;
		end
	end

	// Parser state advances on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			type_q     <= '0;
			len_q      <= '0;
			crc_q      <= CrcInit;
			rx_crc_q   <= '0;
		end else if (in_fire) begin
			in_frame_q <= in_frame_d;
			pos_q      <= pos_d;
			type_q     <= type_d;
			len_q      <= len_d;
			crc_q      <= crc_d;
			rx_crc_q   <= rx_crc_d;
		end
	end

	// Result register and skid entry.
	stxrx_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire && res_valid),
		.push_data (res),
		.space     (buf_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign result_kind  = out_data.kind;
	assign data_byte    = out_data.data_byte;
	assign data_index   = out_data.data_index;
	assign frame_type   = out_data.frame_type;
	assign frame_length = out_data.frame_length;
	assign status       = out_data.status;

	// While hunting, the position counter sits at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (pos_q == '0))
		else $error("position counter not cleared while hunting");

	// Inside a frame the position never returns to zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (pos_q != '0))
		else $error("position counter zero inside a frame");

	// A status result ends the frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res_valid && (res.kind == KIND_DONE)) |=> !in_frame_q)
		else $error("frame still open after its status result");

	// The input only stalls when the output register holds a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty output register");

endmodule
